/* design/acf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the attitude filter.
// Used by acf_ctrl, acf_datapath and the top level; depends on nothing.
package acf_pkg;

    localparam int IN_SCALE_BITS = 14;
    localparam int Z_FRAC_BITS   = 16;
    localparam int CW            = 36;
    localparam int ZW            = 26;
    localparam int SQ_STEPS      = 30;
    localparam int ROOT_W        = 30;
    localparam int REM_W         = 34;
    localparam int RAD_W         = 60;
    localparam int ACC_W         = 62;
    localparam int CNT_W         = 5;
    localparam int CFG_IDX_W     = 2;
    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_DEADBAND = 2'd1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_Y,
        OP_SQ_Z,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_CORDIC_SAVE,
        OP_FIRST,
        OP_PROD,
        OP_MAC_OLD,
        OP_MAC_PLO,
        OP_MAC_PHI,
        OP_MAC_ACC,
        OP_COMMIT,
        OP_YAW,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        AX_ROLL,
        AX_PITCH,
        AX_YAW
    } axis_t;

    typedef struct packed {
        op_t              op;
        axis_t            axis;
        logic [CNT_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic out_busy;
    } sts_t;

    // round(atan(2^-i) * 180/pi * 65536)
    function automatic logic [21:0] atan_entry(input logic [CNT_W-1:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117305;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
        logic signed [23:0] r;
        begin
            if (v > 30'sd8388607)
                r = 24'sh7FFFFF;
            else if (v < -30'sd8388608)
                r = 24'sh800000;
            else
                r = v[23:0];
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        begin
            if (v[32] != v[31])
                r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

/* design/imu_complementary_attitude_filter.sv */
`timescale 1ns / 1ps
// Top level of the IMU complementary attitude filter (roll, pitch, yaw).
// Joins acf_ctrl and acf_datapath; depends on acf_pkg.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------
//  input   | in_valid / in_ready   | accel_x/y/z, rate_x/y/z, time_step
//  output  | out_valid / out_ready | roll_angle, pitch_angle, yaw_angle
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request runs the 30-step bit-serial square root and the two CORDIC passes on one
// shared unit, and the input is not ready again until the sequencer has finished it;
// the first request after reset loads the tilt angles and skips the blend steps.
// A new request is taken while the previous result waits in the output register;
// a stalled output holds the sequencer only at its final step.
// Reset clears the angles and arms the first-sample load; config is always ready.
module imu_complementary_attitude_filter #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   accel_x,
    input  logic signed [15:0]   accel_y,
    input  logic signed [15:0]   accel_z,
    input  logic signed [19:0]   rate_x,
    input  logic signed [19:0]   rate_y,
    input  logic signed [19:0]   rate_z,
    input  logic [15:0]          time_step,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [23:0]   roll_angle,
    output logic signed [23:0]   pitch_angle,
    output logic signed [31:0]   yaw_angle,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [acf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0]          cfg_data
);

    acf_pkg::cmd_t cmd;
    acf_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    acf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    acf_datapath #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .rate_x      (rate_x),
        .rate_y      (rate_y),
        .rate_z      (rate_z),
        .time_step   (time_step),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle)
    );

endmodule

/* design/acf_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the attitude filter: walks each request through square root,
// two CORDIC passes and the blend steps, or the first-sample load. Depends on acf_pkg.
module acf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  acf_pkg::sts_t   sts,
    output acf_pkg::cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_PREP   = 8'b00000010,
        S_SQRT   = 8'b00000100,
        S_CINIT  = 8'b00001000,
        S_CSTEP  = 8'b00010000,
        S_CSAVE  = 8'b00100000,
        S_MAC    = 8'b01000000,
        S_FINISH = 8'b10000000
    } state_t;

    localparam logic [acf_pkg::CNT_W-1:0] CNT_CORDIC_LAST = acf_pkg::CNT_W'(CORDIC_STEPS - 1);
    localparam logic [acf_pkg::CNT_W-1:0] CNT_SQRT_LAST   = acf_pkg::CNT_W'(acf_pkg::SQ_STEPS - 1);

    state_t                      state_reg, state_next;
    logic [acf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    acf_pkg::axis_t              axis_reg, axis_next;
    logic [acf_pkg::CNT_W-1:0]   sub;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd.op     = acf_pkg::OP_NONE;
        cmd.axis   = axis_reg;
        cmd.idx    = cnt_reg;
        sub        = (cnt_reg < 5'd6) ? cnt_reg : cnt_reg - 5'd6;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = acf_pkg::OP_LOAD;
                    cnt_next   = '0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0:    cmd.op = acf_pkg::OP_SQ_Y;
                    5'd1:    cmd.op = acf_pkg::OP_SQ_Z;
                    default:
                    begin
                        cmd.op     = acf_pkg::OP_SQRT_INIT;
                        cnt_next   = '0;
                        state_next = S_SQRT;
                    end
                endcase
            end
            S_SQRT:
            begin
                cmd.op   = acf_pkg::OP_SQRT_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == CNT_SQRT_LAST)
                begin
                    axis_next  = acf_pkg::AX_ROLL;
                    state_next = S_CINIT;
                end
            end
            S_CINIT:
            begin
                cmd.op     = acf_pkg::OP_CORDIC_INIT;
                cnt_next   = '0;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                cmd.op   = acf_pkg::OP_CORDIC_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == CNT_CORDIC_LAST)
                    state_next = S_CSAVE;
            end
            S_CSAVE:
            begin
                cmd.op = acf_pkg::OP_CORDIC_SAVE;
                cnt_next = '0;
                if (axis_reg == acf_pkg::AX_ROLL)
                begin
                    axis_next  = acf_pkg::AX_PITCH;
                    state_next = S_CINIT;
                end
                else
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (sts.first)
                begin
                    cmd.op     = acf_pkg::OP_FIRST;
                    state_next = S_FINISH;
                end
                else if (cnt_reg < 5'd12)
                begin
                    cmd.axis = (cnt_reg < 5'd6) ? acf_pkg::AX_ROLL : acf_pkg::AX_PITCH;
                    case (sub)
                        5'd0:    cmd.op = acf_pkg::OP_PROD;
                        5'd1:    cmd.op = acf_pkg::OP_MAC_OLD;
                        5'd2:    cmd.op = acf_pkg::OP_MAC_PLO;
                        5'd3:    cmd.op = acf_pkg::OP_MAC_PHI;
                        5'd4:    cmd.op = acf_pkg::OP_MAC_ACC;
                        default: cmd.op = acf_pkg::OP_COMMIT;
                    endcase
                end
                else if (cnt_reg == 5'd12)
                begin
                    cmd.axis = acf_pkg::AX_YAW;
                    cmd.op   = acf_pkg::OP_PROD;
                end
                else
                begin
                    cmd.axis   = acf_pkg::AX_YAW;
                    cmd.op     = acf_pkg::OP_YAW;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = acf_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= acf_pkg::AX_ROLL;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_PREP)
        else $error("accepted request did not start the sequence");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == acf_pkg::OP_OUT |-> !sts.out_busy)
        else $error("result loaded over an untaken result");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("input ready while a request is in work");

endmodule

/* design/acf_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the attitude filter: input capture, bit-serial square root,
// shared CORDIC, one shared multiplier-accumulator, angle state and result register.
// Depends on acf_pkg.
module acf_datapath #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  acf_pkg::cmd_t        cmd,
    output acf_pkg::sts_t        sts,
    input  logic signed [15:0]   accel_x,
    input  logic signed [15:0]   accel_y,
    input  logic signed [15:0]   accel_z,
    input  logic signed [19:0]   rate_x,
    input  logic signed [19:0]   rate_y,
    input  logic signed [19:0]   rate_z,
    input  logic [15:0]          time_step,
    input  logic                 cfg_valid,
    input  logic [acf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [23:0]   roll_angle,
    output logic signed [23:0]   pitch_angle,
    output logic signed [31:0]   yaw_angle
);

    localparam int CW = acf_pkg::CW;
    localparam int ZW = acf_pkg::ZW;
    localparam int SH = acf_pkg::Z_FRAC_BITS - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(1) <<< (SH - 1);
    localparam logic signed [ZW-1:0] Z_90   = ZW'(90) <<< acf_pkg::Z_FRAC_BITS;

    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [19:0] gx_reg, gy_reg, gz_reg;
    logic [15:0]        dt_reg;

    logic [16:0] blend_reg;
    logic [15:0] deadband_reg;
    logic [16:0] alpha;
    logic [16:0] alpha_inv;

    logic [31:0]                      sumsq_reg;
    logic [acf_pkg::RAD_W-1:0]        rad_reg;
    logic [acf_pkg::REM_W-1:0]        rem_reg;
    logic [acf_pkg::ROOT_W-1:0]       root_reg;
    logic [acf_pkg::REM_W-1:0]        rem_sh, trial;

    logic signed [CW-1:0] x_reg, y_reg, x0, y0, xs, ys;
    logic signed [ZW-1:0] z_reg, z_rnd, atan_v;
    logic                 zero_reg;

    logic signed [23:0] accr_reg, accp_reg;
    logic signed [23:0] roll_reg, pitch_reg;
    logic signed [31:0] yaw_reg;
    logic               first_reg;

    logic signed [36:0]                p_reg;
    logic signed [acf_pkg::ACC_W-1:0]  acc_reg;
    logic signed [17:0]                ma;
    logic signed [24:0]                mb;
    logic signed [42:0]                prod;
    logic signed [acf_pkg::ACC_W-1:0]  prod_x;
    logic signed [29:0]                blend_rnd;
    logic signed [20:0]                yaw_inc;
    logic [19:0]                       gz_mag;

    logic signed [23:0] old_sel, accang_sel;
    logic signed [19:0] rate_sel;

    assign alpha     = (blend_reg > acf_pkg::ALPHA_ONE) ? acf_pkg::ALPHA_ONE : blend_reg;
    assign alpha_inv = acf_pkg::ALPHA_ONE - alpha;
    assign gz_mag    = gz_reg[19] ? 20'(-gz_reg) : 20'(gz_reg);

    assign old_sel    = (cmd.axis == acf_pkg::AX_ROLL) ? roll_reg : pitch_reg;
    assign accang_sel = (cmd.axis == acf_pkg::AX_ROLL) ? accr_reg : accp_reg;
    always_comb
    begin
        case (cmd.axis)
            acf_pkg::AX_ROLL:  rate_sel = gx_reg;
            acf_pkg::AX_PITCH: rate_sel = gy_reg;
            default:           rate_sel = gz_reg;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        ma = 18'sd0;
        mb = 25'sd0;
        case (cmd.op)
            acf_pkg::OP_SQ_Y:
            begin
                ma = 18'(ay_reg);
                mb = 25'(ay_reg);
            end
            acf_pkg::OP_SQ_Z:
            begin
                ma = 18'(az_reg);
                mb = 25'(az_reg);
            end
            acf_pkg::OP_PROD:
            begin
                ma = $signed({2'b00, dt_reg});
                mb = 25'(rate_sel);
            end
            acf_pkg::OP_MAC_OLD:
            begin
                ma = $signed({1'b0, alpha});
                mb = 25'(old_sel);
            end
            acf_pkg::OP_MAC_PLO:
            begin
                ma = $signed({1'b0, alpha});
                mb = $signed({7'b0, p_reg[17:0]});
            end
            acf_pkg::OP_MAC_PHI:
            begin
                ma = $signed({1'b0, alpha});
                mb = 25'($signed(p_reg[36:18]));
            end
            acf_pkg::OP_MAC_ACC:
            begin
                ma = $signed({1'b0, alpha_inv});
                mb = 25'(accang_sel);
            end
            default:
            begin
                ma = 18'sd0;
                mb = 25'sd0;
            end
        endcase
    end

    assign prod      = ma * mb;
    assign prod_x    = acf_pkg::ACC_W'(prod);
    assign blend_rnd = 30'((acc_reg + (acf_pkg::ACC_W'(1) <<< 31)) >>> 32);
    assign yaw_inc   = 21'((p_reg + 37'sd32768) >>> 16);

    // square root step
    assign rem_sh = {rem_reg[acf_pkg::REM_W-3:0], rad_reg[acf_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    // CORDIC start vector and pre-rotation inputs
    always_comb
    begin
        if (cmd.axis == acf_pkg::AX_ROLL)
        begin
            x0 = CW'(az_reg) <<< acf_pkg::IN_SCALE_BITS;
            y0 = CW'(ay_reg) <<< acf_pkg::IN_SCALE_BITS;
        end
        else
        begin
            x0 = $signed({{(CW - acf_pkg::ROOT_W){1'b0}}, root_reg});
            y0 = (-CW'(ax_reg)) <<< acf_pkg::IN_SCALE_BITS;
        end
    end

    assign xs     = x_reg >>> cmd.idx;
    assign ys     = y_reg >>> cmd.idx;
    assign atan_v = $signed({{(ZW - 22){1'b0}}, acf_pkg::atan_entry(cmd.idx)});
    assign z_rnd  = (z_reg + Z_HALF) >>> SH;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            acf_pkg::OP_LOAD:
            begin
                ax_reg <= accel_x;
                ay_reg <= accel_y;
                az_reg <= accel_z;
                gx_reg <= rate_x;
                gy_reg <= rate_y;
                gz_reg <= rate_z;
                dt_reg <= time_step;
            end
            acf_pkg::OP_SQ_Y:
                sumsq_reg <= prod[31:0];
            acf_pkg::OP_SQ_Z:
                sumsq_reg <= sumsq_reg + prod[31:0];
            acf_pkg::OP_SQRT_INIT:
            begin
                rad_reg  <= {sumsq_reg, {(acf_pkg::RAD_W - 32){1'b0}}};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            acf_pkg::OP_SQRT_STEP:
            begin
                rad_reg <= rad_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[acf_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[acf_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            acf_pkg::OP_CORDIC_INIT:
            begin
                zero_reg <= (x0 == '0) && (y0 == '0);
                if (x0 < 0)
                begin
                    if (y0 >= 0)
                    begin
                        x_reg <= y0;
                        y_reg <= -x0;
                        z_reg <= Z_90;
                    end
                    else
                    begin
                        x_reg <= -y0;
                        y_reg <= x0;
                        z_reg <= -Z_90;
                    end
                end
                else
                begin
                    x_reg <= x0;
                    y_reg <= y0;
                    z_reg <= '0;
                end
            end
            acf_pkg::OP_CORDIC_STEP:
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_v;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_v;
                end
            end
            acf_pkg::OP_CORDIC_SAVE:
            begin
                if (cmd.axis == acf_pkg::AX_ROLL)
                    accr_reg <= zero_reg ? 24'sd0 : 24'(z_rnd);
                else
                    accp_reg <= zero_reg ? 24'sd0 : 24'(z_rnd);
            end
            acf_pkg::OP_PROD:
                p_reg <= prod[36:0];
            acf_pkg::OP_MAC_OLD:
                acc_reg <= prod_x <<< 16;
            acf_pkg::OP_MAC_PLO:
                acc_reg <= acc_reg + prod_x;
            acf_pkg::OP_MAC_PHI:
                acc_reg <= acc_reg + (prod_x <<< 18);
            acf_pkg::OP_MAC_ACC:
                acc_reg <= acc_reg + (prod_x <<< 16);
            default:
            begin
            end
        endcase
    end

    // angle state, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg     <= '0;
            pitch_reg    <= '0;
            yaw_reg      <= '0;
            first_reg    <= 1'b1;
            out_valid    <= 1'b0;
            blend_reg    <= 17'd64225;
            deadband_reg <= 16'd38;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == acf_pkg::CFG_BLEND_WEIGHT)
                    blend_reg <= cfg_data;
                else if (cfg_index == acf_pkg::CFG_YAW_DEADBAND)
                    deadband_reg <= cfg_data[15:0];
            end
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (cmd.op)
                acf_pkg::OP_FIRST:
                begin
                    roll_reg  <= accr_reg;
                    pitch_reg <= accp_reg;
                    yaw_reg   <= '0;
                    first_reg <= 1'b0;
                end
                acf_pkg::OP_COMMIT:
                begin
                    if (cmd.axis == acf_pkg::AX_ROLL)
                        roll_reg <= acf_pkg::sat24(blend_rnd);
                    else
                        pitch_reg <= acf_pkg::sat24(blend_rnd);
                end
                acf_pkg::OP_YAW:
                begin
                    if (gz_mag >= {4'b0, deadband_reg})
                        yaw_reg <= acf_pkg::sat32(33'(yaw_reg) + 33'(yaw_inc));
                end
                acf_pkg::OP_OUT:
                    out_valid <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == acf_pkg::OP_OUT)
        begin
            roll_angle  <= roll_reg;
            pitch_angle <= pitch_reg;
            yaw_angle   <= yaw_reg;
        end
    end

    assign sts.first    = first_reg;
    assign sts.out_busy = out_valid && !out_ready;

    a_first_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == acf_pkg::OP_FIRST |-> first_reg)
        else $error("first-sample load without pending first sample");

    a_deadband_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == acf_pkg::OP_YAW && gz_mag < {4'b0, deadband_reg} |=> $stable(yaw_reg))
        else $error("yaw moved inside deadband");

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == acf_pkg::OP_FIRST |=> !first_reg && yaw_reg == '0)
        else $error("first-sample load did not clear yaw and flag");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for imu_complementary_attitude_filter: directed table, then random IMU samples.
// Results are checked against an in-bench fixed-point attitude predictor; depends on acf_pkg.
module tb;

    localparam int  STEPS      = 16;
    localparam int  FRAC       = 8;
    localparam int  LIMIT      = 1500000;
    localparam int  PHASE_ITEMS = 280;
    localparam int  CFG_UNMAPPED_A = 2;
    localparam int  CFG_UNMAPPED_B = 3;

    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [23:0] roll;
        logic signed [23:0] pitch;
        logic signed [31:0] yaw;
    } attitude_t;

    typedef struct {
        bit                  is_cfg;
        logic [acf_pkg::CFG_IDX_W-1:0] cidx;
        logic [16:0]         cdata;
        logic signed [15:0]  ax, ay, az;
        logic signed [19:0]  gx, gy, gz;
        logic [15:0]         dt;
        bit                  has_exp;
        attitude_t           want;
    } row_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic signed [19:0] rate_x, rate_y, rate_z;
    logic [15:0] time_step;
    logic signed [23:0] roll_angle, pitch_angle;
    logic signed [31:0] yaw_angle;
    logic [acf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [16:0] cfg_data;

    attitude_t attitude_q[$];
    row_t      rows[$];
    int        errors;
    int        cycles;
    bit        rx_hold_req;

    // predictor state
    longint p_roll, p_pitch, p_yaw;
    bit     p_first;
    longint p_alpha, p_deadband;

    imu_complementary_attitude_filter dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end
            else
            begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += ATAN_Q16[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ATAN_Q16[i];
            end
        end
        return round_shift(z, 16 - FRAC);
    endfunction

    function automatic longint fuse(longint old, longint rate, longint dt, longint acc, longint a);
        longint v;
        v = a * (old * 65536 + rate * dt) + (65536 - a) * (acc * 65536);
        return clamp(round_shift(v, 32), 24);
    endfunction

    function automatic attitude_t update_attitude(row_t r);
        longint ax, ay, az, gz, horiz, tilt_roll, tilt_pitch, a, mag;
        attitude_t res;
        ax = r.ax; ay = r.ay; az = r.az; gz = r.gz;
        horiz = int_sqrt(longint'(ay * ay + az * az) << 28);
        tilt_roll = vector_angle(ay * 16384, az * 16384);
        tilt_pitch = vector_angle(-ax * 16384, horiz);
        if (p_first)
        begin
            p_roll = clamp(tilt_roll, 24);
            p_pitch = clamp(tilt_pitch, 24);
            p_yaw = 0;
            p_first = 0;
        end
        else
        begin
            a = p_alpha > 65536 ? 65536 : p_alpha;
            mag = gz < 0 ? -gz : gz;
            p_roll = fuse(p_roll, longint'(r.gx), longint'(r.dt), tilt_roll, a);
            p_pitch = fuse(p_pitch, longint'(r.gy), longint'(r.dt), tilt_pitch, a);
            if (mag >= p_deadband)
                p_yaw = clamp(p_yaw + round_shift(gz * longint'(r.dt), 16), 32);
        end
        res.roll = p_roll[23:0];
        res.pitch = p_pitch[23:0];
        res.yaw = p_yaw[31:0];
        return res;
    endfunction

    task automatic add_item(longint ax, longint ay, longint az, longint gx, longint gy,
                            longint gz, longint dt);
        row_t r;
        r = '{default: 0};
        r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az);
        r.gx = 20'(gx); r.gy = 20'(gy); r.gz = 20'(gz); r.dt = 16'(dt);
        rows.push_back(r);
    endtask

    task automatic add_cfg(int idx, int data);
        row_t r;
        r = '{default: 0};
        r.is_cfg = 1;
        r.cidx = acf_pkg::CFG_IDX_W'(idx);
        r.cdata = 17'(data);
        rows.push_back(r);
    endtask

    // caller is just past a rising edge; valid stays high after acceptance
    task automatic send_item(row_t r);
        attitude_t e;
        accel_x <= r.ax; accel_y <= r.ay; accel_z <= r.az;
        rate_x <= r.gx; rate_y <= r.gy; rate_z <= r.gz;
        time_step <= r.dt;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        e = update_attitude(r);
        if (r.has_exp)
            e = r.want;
        attitude_q.push_back(e);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        wait (attitude_q.size() == 0);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(int idx, int data);
        drain();
        cfg_index <= acf_pkg::CFG_IDX_W'(idx);
        cfg_data <= 17'(data);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == acf_pkg::CFG_BLEND_WEIGHT)
            p_alpha = data & 17'h1FFFF;
        else if (idx == acf_pkg::CFG_YAW_DEADBAND)
            p_deadband = data & 16'hFFFF;
        @(posedge clk);
    endtask

    function automatic longint rand_accel();
        case ($urandom_range(0, 5))
            0: return 0;
            1, 2: return $signed(16'($urandom));
            default: return longint'($urandom_range(0, 8000)) - 4000;
        endcase
    endfunction

    function automatic longint rand_rate();
        case ($urandom_range(0, 4))
            0: return $signed(20'($urandom));
            1: return longint'($urandom_range(0, 100)) - 50;
            default: return longint'($urandom_range(0, 20000)) - 10000;
        endcase
    endfunction

    task automatic random_phase(int n);
        row_t r;
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0)
            begin
                r = '{default: 0};
                r.ax = 16'(rand_accel()); r.ay = 16'(rand_accel()); r.az = 16'(rand_accel());
                r.gx = 20'(rand_rate()); r.gy = 20'(rand_rate()); r.gz = 20'(rand_rate());
                r.dt = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 2000));
                send_item(r);
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 150)) @(posedge clk);
            end
        end
    endtask

    // receiver stall pattern, plus a long hold-off on request
    initial
    begin
        int mode, span;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (800) @(posedge clk);
                rx_hold_req <= 1'b0;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 9) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        attitude_t e;
        if (out_valid && out_ready)
        begin
            if (attitude_q.size() == 0)
            begin
                $display("%t unexpected result roll %0d pitch %0d yaw %0d", $time,
                         roll_angle, pitch_angle, yaw_angle);
                errors++;
            end
            else
            begin
                e = attitude_q.pop_front();
                if (roll_angle !== e.roll)
                begin
                    $display("%t roll expected %0d actual %0d", $time, e.roll, roll_angle);
                    errors++;
                end
                if (pitch_angle !== e.pitch)
                begin
                    $display("%t pitch expected %0d actual %0d", $time, e.pitch, pitch_angle);
                    errors++;
                end
                if (yaw_angle !== e.yaw)
                begin
                    $display("%t yaw expected %0d actual %0d", $time, e.yaw, yaw_angle);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        row_t r;
        errors = 0;
        cycles = 0;
        rx_hold_req = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        accel_x = '0; accel_y = '0; accel_z = '0;
        rate_x = '0; rate_y = '0; rate_z = '0;
        time_step = '0;
        p_roll = 0; p_pitch = 0; p_yaw = 0; p_first = 1;
        p_alpha = 64225; p_deadband = 38;

        // zero vector on the first sample: everything reads zero
        add_item(0, 0, 0, 1000, -1000, 5000, 65535);
        rows[0].has_exp = 1;
        rows[0].want = '{roll: 0, pitch: 0, yaw: 0};
        add_item(0, 0, 32767, 0, 0, 0, 0);
        add_item(-32768, -32768, -32768, 524287, 524287, 524287, 65535);
        add_item(32767, 32767, 32767, -524288, -524288, -524288, 65535);
        add_item(0, 0, -100, 100, 100, 100, 100);
        add_item(0, -5, -100, 0, 0, 0, 1);
        add_item(7, 3, 2000, 0, 0, 37, 1000);
        add_item(7, 3, 2000, 0, 0, -38, 1000);
        add_cfg(acf_pkg::CFG_BLEND_WEIGHT, 65536);
        add_item(1000, 500, 4000, 3000, -3000, 400, 6553);
        add_cfg(acf_pkg::CFG_BLEND_WEIGHT, 131071);
        add_item(-1000, 500, -4000, 3000, -3000, 400, 6553);
        add_cfg(acf_pkg::CFG_BLEND_WEIGHT, 0);
        add_item(200, -300, 4000, 500, 500, 500, 500);
        add_cfg(CFG_UNMAPPED_A, 17'h1FFFF);
        add_cfg(CFG_UNMAPPED_B, 17'h0AAAA);
        add_item(-200, 300, 4000, 500, 500, 500, 500);
        add_cfg(acf_pkg::CFG_YAW_DEADBAND, 0);
        add_item(0, 100, 100, 0, 0, 0, 65535);
        add_cfg(acf_pkg::CFG_YAW_DEADBAND, 65535);
        add_item(0, 100, 100, 0, 0, -524288, 65535);
        add_item(0, 100, 100, 0, 0, 65534, 65535);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.is_cfg)
                write_reg(r.cidx, r.cdata);
            else
                send_item(r);
        end

        write_reg(acf_pkg::CFG_BLEND_WEIGHT, 64225);
        write_reg(acf_pkg::CFG_YAW_DEADBAND, 38);
        random_phase(PHASE_ITEMS);

        // long receiver hold-off while requests keep coming
        rx_hold_req <= 1'b1;
        random_phase(10);
        drain();

        write_reg(acf_pkg::CFG_BLEND_WEIGHT, 0);
        random_phase(PHASE_ITEMS);
        write_reg(acf_pkg::CFG_BLEND_WEIGHT, 65536);
        write_reg(acf_pkg::CFG_YAW_DEADBAND, 0);
        random_phase(PHASE_ITEMS);
        write_reg(acf_pkg::CFG_BLEND_WEIGHT, 131071);
        write_reg(acf_pkg::CFG_YAW_DEADBAND, 65535);
        random_phase(PHASE_ITEMS);
        write_reg(acf_pkg::CFG_BLEND_WEIGHT, $urandom_range(0, 65536));
        write_reg(acf_pkg::CFG_YAW_DEADBAND, $urandom_range(0, 2000));
        random_phase(PHASE_ITEMS);
        write_reg(acf_pkg::CFG_BLEND_WEIGHT, 32768);
        write_reg(acf_pkg::CFG_YAW_DEADBAND, 38);
        random_phase(PHASE_ITEMS);

        in_valid <= 1'b0;
        wait (attitude_q.size() == 0);
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
